// File: rtl/dp2a_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dp2a_pkg
// Types, constants and the binary-to-BCD step shared by the key-path ASCII
// converter.
// ----------------------------------------------------------------------------
package dp2a_pkg;

  localparam int ELEM_W     = 32;
  localparam int NUM_W      = ELEM_W - 1;
  localparam int DIGITS     = 10;
  localparam int BCD_W      = DIGITS * 4;
  localparam int DIG_IDX_W  = $clog2(DIGITS);
  localparam int DD_PER_STG = 8;
  localparam int DD_STG     = (NUM_W + DD_PER_STG - 1) / DD_PER_STG;
  localparam int CHR_W      = 7;

  localparam logic [CHR_W-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CHR_W-1:0] ASCII_NINE  = 7'h39;
  localparam logic [CHR_W-1:0] ASCII_APOS  = 7'h27;
  localparam logic [CHR_W-1:0] ASCII_SLASH = 7'h2F;
  localparam logic [CHR_W-1:0] ASCII_NUL   = 7'h00;

  typedef struct packed {
    logic [ELEM_W-1:0] path_element;
    logic              is_final_element;
  } in_t;

  typedef struct packed {
    logic [CHR_W-1:0] ascii_char;
    logic             run_end;
  } out_t;

  typedef logic [DIGITS-1:0][3:0] bcd_t;

  typedef struct packed {
    bcd_t             bcd;
    logic [NUM_W-1:0] bin;
    logic             hard;
    logic             fin;
  } stg_t;

  typedef enum logic [1:0] {
    PH_DIG,
    PH_APOS,
    PH_SEP
  } phase_t;

  // One shift-add-3 iteration: correct each BCD digit, then shift in the
  // next binary bit.
  function automatic stg_t dd_step(stg_t s);
    stg_t             r;
    bcd_t             adj;
    logic [BCD_W-1:0] flat;
    r   = s;
    adj = s.bcd;
    for (int d = 0; d < DIGITS; d++) begin
      if (s.bcd[d] >= 4'd5) begin
        adj[d] = s.bcd[d] + 4'd3;
      end
    end
    flat  = adj;
    r.bcd = {flat[BCD_W-2:0], s.bin[NUM_W-1]};
    r.bin = {s.bin[NUM_W-2:0], 1'b0};
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/derivation_path_to_ascii_core.sv
`default_nettype none
// Path: the first character of an element reaches out_data through the input
//   register, the 4 BCD stages, the serializer load and the output register.
// Throughput: one character per cycle, set by the single-character output
//   channel, while out_ready allows; an element is 2 to 12 characters.
// Reset: rst_n clears all valid bits and the serializer; data regs hold.
// ----------------------------------------------------------------------------
// derivation_path_to_ascii_core
// Converts one 32-bit key-path element per transaction into its ASCII text:
// decimal digits, an optional apostrophe, then '/' or a NUL terminator.
// ----------------------------------------------------------------------------
module derivation_path_to_ascii_core
  import dp2a_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  wire  out_ready,
  output out_t out_data
);

  // --------------------------------------------------------------------------
  // Conversion pipeline. Stage 0 is the input register; stages 1..DD_STG
  // each run up to DD_PER_STG shift-add-3 iterations on the element's low
  // 31 bits. Valid bits travel with the data and a stage advances only when
  // the stage after it can take its contents, so nothing is lost on a stall.
  // --------------------------------------------------------------------------
  stg_t              stg_r   [DD_STG+1];
  stg_t              stg_nxt [DD_STG+1];
  logic [DD_STG:0]   v_r;
  logic [DD_STG:0]   rdy;

  // Serializer state
  logic              ser_busy_r, ser_busy_nxt;
  phase_t            phase_r, phase_nxt;
  logic [DIG_IDX_W-1:0] dig_r, dig_nxt;
  bcd_t              bcd_r;
  logic              hard_r;
  logic              fin_r;
  logic              ser_take;
  logic              ser_load;
  logic              emit;
  logic [DIG_IDX_W-1:0] top_dig;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  // Stage 0 takes the raw element: empty BCD, number bits left-aligned.
  always_comb begin
    stg_nxt[0].bcd  = '0;
    stg_nxt[0].bin  = in_data.path_element[NUM_W-1:0];
    stg_nxt[0].hard = in_data.path_element[ELEM_W-1];
    stg_nxt[0].fin  = in_data.is_final_element;
    for (int k = 1; k <= DD_STG; k++) begin
      stg_nxt[k] = stg_r[k-1];
      for (int i = 0; i < DD_PER_STG; i++) begin
        if ((k - 1) * DD_PER_STG + i < NUM_W) begin
          stg_nxt[k] = dd_step(stg_nxt[k]);
        end
      end
    end
  end

  // Ready chain: a stage can load when it is empty or drains this cycle.
  always_comb begin
    rdy[DD_STG] = !v_r[DD_STG] || ser_take;
    for (int k = DD_STG - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k <= DD_STG; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= DD_STG; k++) begin
      if (rdy[k]) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Serializer. Holds one converted element and walks it out one character
  // per cycle as out_ready allows: digits from the most significant nonzero
  // one down, then the hardened apostrophe, then the separator. A new element
  // loads in the same cycle the separator leaves, so elements run gap-free.
  // --------------------------------------------------------------------------

  // Most significant nonzero digit; zero prints as a single '0'.
  always_comb begin
    top_dig = '0;
    for (int d = 0; d < DIGITS; d++) begin
      if (stg_r[DD_STG].bcd[d] != 4'd0) begin
        top_dig = DIG_IDX_W'(d);
      end
    end
  end

  assign emit     = ser_busy_r && (!out_valid_r || out_ready);
  assign ser_take = !ser_busy_r || (emit && (phase_r == PH_SEP));
  assign ser_load = v_r[DD_STG] && ser_take;

  always_comb begin
    phase_nxt    = phase_r;
    dig_nxt      = dig_r;
    ser_busy_nxt = ser_busy_r;
    out_nxt      = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (emit) begin
      out_valid_nxt = 1'b1;
      case (phase_r)
        PH_DIG: begin
          out_nxt.ascii_char = ASCII_ZERO + CHR_W'(bcd_r[dig_r]);
          out_nxt.run_end    = 1'b0;
          if (dig_r == '0) begin
            phase_nxt = hard_r ? PH_APOS : PH_SEP;
          end else begin
            dig_nxt = dig_r - 1'b1;
          end
        end
        PH_APOS: begin
          out_nxt.ascii_char = ASCII_APOS;
          out_nxt.run_end    = 1'b0;
          phase_nxt          = PH_SEP;
        end
        PH_SEP: begin
          out_nxt.ascii_char = fin_r ? ASCII_NUL : ASCII_SLASH;
          out_nxt.run_end    = 1'b1;
          ser_busy_nxt       = 1'b0;
        end
        default: begin
          out_nxt.ascii_char = ASCII_NUL;
          out_nxt.run_end    = 1'b1;
          ser_busy_nxt       = 1'b0;
        end
      endcase
    end
    // Load the next element; overrides the drain of the one just finished.
    if (ser_load) begin
      ser_busy_nxt = 1'b1;
      phase_nxt    = PH_DIG;
      dig_nxt      = top_dig;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_busy_r  <= 1'b0;
      phase_r     <= PH_DIG;
      dig_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ser_busy_r  <= ser_busy_nxt;
      phase_r     <= phase_nxt;
      dig_r       <= dig_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (ser_load) begin
      bcd_r  <= stg_r[DD_STG].bcd;
      hard_r <= stg_r[DD_STG].hard;
      fin_r  <= stg_r[DD_STG].fin;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  // Run end marks exactly the separator or terminator characters.
  a_run_end_sep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.run_end == ((out_r.ascii_char == ASCII_NUL) ||
                                      (out_r.ascii_char == ASCII_SLASH))))
    else $error("run_end does not match separator character");

  // Anything that is not a separator or apostrophe must be a decimal digit.
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.run_end && (out_r.ascii_char != ASCII_APOS)) |->
      ((out_r.ascii_char >= ASCII_ZERO) && (out_r.ascii_char <= ASCII_NINE)))
    else $error("non-digit character in digit position");

  // A blocked last stage holds its element until the serializer takes it.
  a_last_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[DD_STG] && !ser_take) |=> (v_r[DD_STG] && $stable(stg_r[DD_STG])))
    else $error("last conversion stage changed while stalled");
`endif

endmodule
`default_nettype wire
